>>> src/lfur_pkg.sv
// ----------------------------------------------------------------------------
// lfur_pkg
// shared types, codes and constants of the lagged fibonacci uniform generator
// ----------------------------------------------------------------------------
package lfur_pkg;

    // input item operation codes
    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    // seed reduction and split
    localparam int   SEED_W       = 31;
    localparam int   DVS_W        = 30;
    localparam logic [DVS_W-1:0] SEED_MODULUS = 30'd899999963;
    localparam logic [DVS_W-1:0] SEED_SPLIT   = 30'd30082;
    localparam logic [DVS_W-1:0] SPLIT_HI     = 30'd177;
    localparam logic [DVS_W-1:0] SPLIT_LO     = 30'd169;

    // seed fold: a 31-bit seed is below three times the modulus
    localparam logic [SEED_W-1:0] SEED_MODULUS_X2 = 31'd1799999926;

    // reciprocal multiply for the split divisions
    localparam logic [SEED_W-1:0] RECIP_SPLIT = 31'd1169615455; // ceil(2^45 / 30082)
    localparam logic [SEED_W-1:0] RECIP_HI    = 31'd47394;      // ceil(2^23 / 177)
    localparam logic [SEED_W-1:0] RECIP_LO    = 31'd49637;      // ceil(2^23 / 169)
    localparam int   SHIFT_SPLIT = 45;
    localparam int   SHIFT_SMALL = 23;

    // seeding recurrences: mod 179 and mod 169 by reciprocal multiply
    localparam logic [14:0] MOD_M    = 15'd179;
    localparam logic [29:0] RECIP_M  = 30'd23432;   // ceil(2^22 / 179)
    localparam logic [13:0] MOD_D    = 14'd169;
    localparam logic [25:0] RECIP_D  = 26'd6205;    // ceil(2^20 / 169)
    localparam logic [13:0] D_MULT   = 14'd53;

    // lag table
    localparam int   LAG_LEN     = 97;
    localparam logic [6:0] LAG_LAST    = 7'd96;
    localparam logic [6:0] LAG_A_RESET = 7'd96;
    localparam logic [6:0] LAG_B_RESET = 7'd32;
    localparam logic [4:0] BIT_LAST    = 5'd23;

    // weyl carry
    localparam logic [23:0] CARRY_INIT = 24'd362436;
    localparam logic [23:0] CARRY_DEC  = 24'd7654321;
    localparam logic [23:0] CARRY_WRAP = 24'd9122892;  // 16777213 - 7654321

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_AB,
        ST_QUO_AB,
        ST_REM_AB,
        ST_MUL_C,
        ST_QUO_C,
        ST_REM_C,
        ST_BIT,
        ST_DRAW_RD,
        ST_DRAW_WR
    } state_t;

    typedef enum logic [1:0] {
        DIV_SEED,
        DIV_SPLIT,
        DIV_HI,
        DIV_LO
    } div_sel_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_MUL_AB,
        STEP_QUO,
        STEP_REM_AB,
        STEP_MUL_C,
        STEP_REM_C,
        STEP_BIT
    } fill_step_t;

    typedef struct packed {
        logic       load_seed;
        logic       div_start;
        logic       div_capture;
        div_sel_t   div_sel;
        logic       fill_init;
        fill_step_t step;
        logic       draw_update;
        logic       out_unseeded;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic bit_last;
        logic entry_last;
        logic seeded;
    } ctrl_status_t;

endpackage

>>> src/lfur_div.sv
// ----------------------------------------------------------------------------
// lfur_div
// constant divider: seed fold by compare, splits by reciprocal multiply
// ----------------------------------------------------------------------------
module lfur_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lfur_pkg::SEED_W-1:0]  dividend,
    input  lfur_pkg::div_sel_t           sel,
    output logic                         done,
    output logic [lfur_pkg::SEED_W-1:0]  quotient,
    output logic [lfur_pkg::DVS_W-1:0]   remainder
);

    logic [lfur_pkg::SEED_W-1:0]   dvd_reg;
    lfur_pkg::div_sel_t            sel_reg;
    logic [lfur_pkg::SEED_W-1:0]   quo_reg;
    logic [lfur_pkg::DVS_W-1:0]    rem_reg;
    logic                          quo_stage_reg;
    logic                          rem_stage_reg;
    logic                          done_reg;

    logic [lfur_pkg::SEED_W-1:0]   recip;
    logic [lfur_pkg::DVS_W-1:0]    divisor;
    logic [2*lfur_pkg::SEED_W-1:0] prod;
    logic [2*lfur_pkg::SEED_W-1:0] prod_split;
    logic [2*lfur_pkg::SEED_W-1:0] prod_small;
    logic [lfur_pkg::SEED_W-1:0]   quo_next;
    logic [lfur_pkg::SEED_W-1:0]   back;
    logic [lfur_pkg::SEED_W-1:0]   rem_full;

    always_comb
    begin
        case (sel_reg)
            lfur_pkg::DIV_SEED:
            begin
                recip   = '0;
                divisor = lfur_pkg::SEED_MODULUS;
            end
            lfur_pkg::DIV_SPLIT:
            begin
                recip   = lfur_pkg::RECIP_SPLIT;
                divisor = lfur_pkg::SEED_SPLIT;
            end
            lfur_pkg::DIV_HI:
            begin
                recip   = lfur_pkg::RECIP_HI;
                divisor = lfur_pkg::SPLIT_HI;
            end
            default:
            begin
                recip   = lfur_pkg::RECIP_LO;
                divisor = lfur_pkg::SPLIT_LO;
            end
        endcase
    end

    assign prod       = {{lfur_pkg::SEED_W{1'b0}}, dvd_reg} * {{lfur_pkg::SEED_W{1'b0}}, recip};
    assign prod_split = prod >> lfur_pkg::SHIFT_SPLIT;
    assign prod_small = prod >> lfur_pkg::SHIFT_SMALL;

    // quotient: at most two moduli fit in a seed, the rest by reciprocal
    always_comb
    begin
        case (sel_reg)
            lfur_pkg::DIV_SEED:
            begin
                if (dvd_reg >= lfur_pkg::SEED_MODULUS_X2)
                begin
                    quo_next = 31'd2;
                end
                else if (dvd_reg >= {1'b0, lfur_pkg::SEED_MODULUS})
                begin
                    quo_next = 31'd1;
                end
                else
                begin
                    quo_next = '0;
                end
            end
            lfur_pkg::DIV_SPLIT:
            begin
                quo_next = prod_split[lfur_pkg::SEED_W-1:0];
            end
            default:
            begin
                quo_next = prod_small[lfur_pkg::SEED_W-1:0];
            end
        endcase
    end

    assign back     = quo_reg * {1'b0, divisor};
    assign rem_full = dvd_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_stage_reg <= 1'b0;
            rem_stage_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            quo_stage_reg <= start;
            rem_stage_reg <= quo_stage_reg;
            done_reg      <= rem_stage_reg;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            sel_reg <= sel;
        end
        if (quo_stage_reg)
        begin
            quo_reg <= quo_next;
        end
        if (rem_stage_reg)
        begin
            rem_reg <= rem_full[lfur_pkg::DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/lfur_dp.sv
// ----------------------------------------------------------------------------
// lfur_dp
// datapath: seed split, table fill recurrences, lag table and draw arithmetic
// ----------------------------------------------------------------------------
module lfur_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfur_pkg::ctrl_cmd_t          cmd,
    output lfur_pkg::ctrl_status_t       status,
    input  logic [lfur_pkg::SEED_W-1:0]  seed,
    output logic                         valid,
    output logic [23:0]                  value,
    output logic                         unseeded
);

    // seed split
    logic [lfur_pkg::SEED_W-1:0] seed_reg;
    logic [lfur_pkg::DVS_W-1:0]  r_reg;
    logic [14:0]                 hi_reg;
    logic [14:0]                 lo_reg;

    logic [lfur_pkg::SEED_W-1:0] div_dividend;
    logic                        div_done;
    logic [lfur_pkg::SEED_W-1:0] div_quo;
    logic [lfur_pkg::DVS_W-1:0]  div_rem;

    // fill recurrences
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, t_reg;
    logic [14:0] p_reg;
    logic [7:0]  q_reg;
    logic [13:0] pd_reg;
    logic [5:0]  qd_reg;
    logic [22:0] acc_reg;
    logic [4:0]  bit_cnt_reg;
    logic [6:0]  entry_reg;

    logic [15:0] mul_ab;
    logic [15:0] mul_c;
    logic [29:0] recip_m;
    logic [25:0] recip_d;
    logic [14:0] rem_m;
    logic [13:0] rem_d;
    logic [13:0] pd_next;
    logic [11:0] bit_prod;
    logic        new_bit;

    // lag table and draw
    logic [23:0] lag_mem [0:lfur_pkg::LAG_LEN-1];
    logic [23:0] rd_a_reg, rd_b_reg;
    logic [6:0]  ia_reg, ib_reg;
    logic [23:0] carry_reg;
    logic        seeded_reg;
    logic [23:0] diff;
    logic [23:0] carry_next;
    logic        mem_we;
    logic [6:0]  mem_waddr;
    logic [23:0] mem_wdata;

    logic [23:0] value_reg;
    logic        unseeded_reg;
    logic        valid_reg;

    always_comb
    begin
        case (cmd.div_sel)
            lfur_pkg::DIV_SEED:
            begin
                div_dividend = seed_reg;
            end
            lfur_pkg::DIV_SPLIT:
            begin
                div_dividend = {1'b0, r_reg};
            end
            lfur_pkg::DIV_HI:
            begin
                div_dividend = {16'b0, hi_reg};
            end
            default:
            begin
                div_dividend = {16'b0, lo_reg};
            end
        endcase
    end

    lfur_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .sel       (cmd.div_sel),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // recurrence arithmetic for the fill steps
    assign mul_ab   = {8'b0, a_reg} * {8'b0, b_reg};
    assign mul_c    = {8'b0, t_reg} * {8'b0, c_reg};
    assign recip_m  = {15'b0, p_reg} * lfur_pkg::RECIP_M;
    assign recip_d  = {12'b0, pd_reg} * lfur_pkg::RECIP_D;
    assign rem_m    = p_reg - ({7'b0, q_reg} * lfur_pkg::MOD_M);
    assign rem_d    = pd_reg - ({8'b0, qd_reg} * lfur_pkg::MOD_D);
    assign pd_next  = (lfur_pkg::D_MULT * {6'b0, d_reg}) + 14'd1;
    // bit 5 of d*m only depends on the low six bits of each
    assign bit_prod = {6'b0, d_reg[5:0]} * {6'b0, c_reg[5:0]};
    assign new_bit  = bit_prod[5];

    // draw arithmetic, all modulo 2^24
    assign diff       = rd_a_reg - rd_b_reg;
    assign carry_next = (carry_reg >= lfur_pkg::CARRY_DEC) ? (carry_reg - lfur_pkg::CARRY_DEC)
                                                          : (carry_reg + lfur_pkg::CARRY_WRAP);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = entry_reg;
        mem_wdata = {acc_reg, new_bit};
        if (cmd.step == lfur_pkg::STEP_BIT && bit_cnt_reg == lfur_pkg::BIT_LAST)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.draw_update)
        begin
            mem_we    = 1'b1;
            mem_waddr = ia_reg;
            mem_wdata = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lag_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= lag_mem[ia_reg];
        rd_b_reg <= lag_mem[ib_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            seed_reg <= seed;
        end
        if (cmd.div_capture && cmd.div_sel == lfur_pkg::DIV_SEED)
        begin
            r_reg <= div_rem;
        end
        if (cmd.div_capture && cmd.div_sel == lfur_pkg::DIV_SPLIT)
        begin
            hi_reg <= div_quo[14:0];
            lo_reg <= div_rem[14:0];
        end
        case (cmd.step)
            lfur_pkg::STEP_MUL_AB:
            begin
                p_reg  <= mul_ab[14:0];
                pd_reg <= pd_next;
            end
            lfur_pkg::STEP_QUO:
            begin
                q_reg  <= recip_m[29:22];
                qd_reg <= recip_d[25:20];
            end
            lfur_pkg::STEP_REM_AB:
            begin
                t_reg <= rem_m[7:0];
            end
            lfur_pkg::STEP_MUL_C:
            begin
                p_reg <= mul_c[14:0];
            end
            lfur_pkg::STEP_BIT:
            begin
                acc_reg <= {acc_reg[21:0], new_bit};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            d_reg        <= '0;
            bit_cnt_reg  <= '0;
            entry_reg    <= '0;
            ia_reg       <= lfur_pkg::LAG_A_RESET;
            ib_reg       <= lfur_pkg::LAG_B_RESET;
            carry_reg    <= lfur_pkg::CARRY_INIT;
            seeded_reg   <= 1'b0;
            valid_reg    <= 1'b0;
            unseeded_reg <= 1'b0;
            value_reg    <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cmd.div_capture && cmd.div_sel == lfur_pkg::DIV_HI)
            begin
                a_reg <= div_quo[7:0] + 8'd2;
                b_reg <= div_rem[7:0] + 8'd2;
            end
            if (cmd.div_capture && cmd.div_sel == lfur_pkg::DIV_LO)
            begin
                c_reg <= div_quo[7:0] + 8'd1;
                d_reg <= div_rem[7:0];
            end
            if (cmd.fill_init)
            begin
                bit_cnt_reg <= '0;
                entry_reg   <= '0;
            end
            if (cmd.step == lfur_pkg::STEP_REM_AB)
            begin
                d_reg <= rem_d[7:0];
            end
            if (cmd.step == lfur_pkg::STEP_REM_C)
            begin
                a_reg <= b_reg;
                b_reg <= c_reg;
                c_reg <= rem_m[7:0];
            end
            if (cmd.step == lfur_pkg::STEP_BIT)
            begin
                if (bit_cnt_reg == lfur_pkg::BIT_LAST)
                begin
                    bit_cnt_reg <= '0;
                    entry_reg   <= entry_reg + 7'd1;
                    if (entry_reg == lfur_pkg::LAG_LAST)
                    begin
                        ia_reg     <= lfur_pkg::LAG_A_RESET;
                        ib_reg     <= lfur_pkg::LAG_B_RESET;
                        carry_reg  <= lfur_pkg::CARRY_INIT;
                        seeded_reg <= 1'b1;
                    end
                end
                else
                begin
                    bit_cnt_reg <= bit_cnt_reg + 5'd1;
                end
            end
            if (cmd.draw_update)
            begin
                ia_reg       <= (ia_reg == 7'd0) ? lfur_pkg::LAG_LAST : (ia_reg - 7'd1);
                ib_reg       <= (ib_reg == 7'd0) ? lfur_pkg::LAG_LAST : (ib_reg - 7'd1);
                carry_reg    <= carry_next;
                value_reg    <= diff - carry_next;
                unseeded_reg <= 1'b0;
                valid_reg    <= 1'b1;
            end
            else if (cmd.out_unseeded)
            begin
                value_reg    <= '0;
                unseeded_reg <= 1'b1;
                valid_reg    <= 1'b1;
            end
        end
    end

    assign status.div_done   = div_done;
    assign status.bit_last   = (bit_cnt_reg == lfur_pkg::BIT_LAST);
    assign status.entry_last = (entry_reg == lfur_pkg::LAG_LAST);
    assign status.seeded     = seeded_reg;

    assign valid    = valid_reg;
    assign value    = value_reg;
    assign unseeded = unseeded_reg;

endmodule

>>> src/lfur_ctrl.sv
// ----------------------------------------------------------------------------
// lfur_ctrl
// controller: sequences seed split, table fill and draw steps
// ----------------------------------------------------------------------------
module lfur_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    operation,
    output logic                    busy,
    output lfur_pkg::ctrl_cmd_t     cmd,
    input  lfur_pkg::ctrl_status_t  status
);

    lfur_pkg::state_t   state_reg, state_next;
    lfur_pkg::div_sel_t div_sel_reg, div_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lfur_pkg::ST_IDLE;
            div_sel_reg <= lfur_pkg::DIV_SEED;
        end
        else
        begin
            state_reg   <= state_next;
            div_sel_reg <= div_sel_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        div_sel_next     = div_sel_reg;
        cmd.load_seed    = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.div_capture  = 1'b0;
        cmd.div_sel      = div_sel_reg;
        cmd.fill_init    = 1'b0;
        cmd.step         = lfur_pkg::STEP_NONE;
        cmd.draw_update  = 1'b0;
        cmd.out_unseeded = 1'b0;

        case (state_reg)
            lfur_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == lfur_pkg::OP_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        div_sel_next  = lfur_pkg::DIV_SEED;
                        state_next    = lfur_pkg::ST_DIV_GO;
                    end
                    else if (status.seeded)
                    begin
                        state_next = lfur_pkg::ST_DRAW_RD;
                    end
                    else
                    begin
                        cmd.out_unseeded = 1'b1;
                    end
                end
            end
            lfur_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = lfur_pkg::ST_DIV_WAIT;
            end
            lfur_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    case (div_sel_reg)
                        lfur_pkg::DIV_SEED:
                        begin
                            div_sel_next = lfur_pkg::DIV_SPLIT;
                            state_next   = lfur_pkg::ST_DIV_GO;
                        end
                        lfur_pkg::DIV_SPLIT:
                        begin
                            div_sel_next = lfur_pkg::DIV_HI;
                            state_next   = lfur_pkg::ST_DIV_GO;
                        end
                        lfur_pkg::DIV_HI:
                        begin
                            div_sel_next = lfur_pkg::DIV_LO;
                            state_next   = lfur_pkg::ST_DIV_GO;
                        end
                        default:
                        begin
                            cmd.fill_init = 1'b1;
                            state_next    = lfur_pkg::ST_MUL_AB;
                        end
                    endcase
                end
            end
            lfur_pkg::ST_MUL_AB:
            begin
                cmd.step   = lfur_pkg::STEP_MUL_AB;
                state_next = lfur_pkg::ST_QUO_AB;
            end
            lfur_pkg::ST_QUO_AB:
            begin
                cmd.step   = lfur_pkg::STEP_QUO;
                state_next = lfur_pkg::ST_REM_AB;
            end
            lfur_pkg::ST_REM_AB:
            begin
                cmd.step   = lfur_pkg::STEP_REM_AB;
                state_next = lfur_pkg::ST_MUL_C;
            end
            lfur_pkg::ST_MUL_C:
            begin
                cmd.step   = lfur_pkg::STEP_MUL_C;
                state_next = lfur_pkg::ST_QUO_C;
            end
            lfur_pkg::ST_QUO_C:
            begin
                cmd.step   = lfur_pkg::STEP_QUO;
                state_next = lfur_pkg::ST_REM_C;
            end
            lfur_pkg::ST_REM_C:
            begin
                cmd.step   = lfur_pkg::STEP_REM_C;
                state_next = lfur_pkg::ST_BIT;
            end
            lfur_pkg::ST_BIT:
            begin
                cmd.step = lfur_pkg::STEP_BIT;
                if (status.bit_last && status.entry_last)
                begin
                    state_next = lfur_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lfur_pkg::ST_MUL_AB;
                end
            end
            lfur_pkg::ST_DRAW_RD:
            begin
                state_next = lfur_pkg::ST_DRAW_WR;
            end
            lfur_pkg::ST_DRAW_WR:
            begin
                cmd.draw_update = 1'b1;
                state_next      = lfur_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lfur_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != lfur_pkg::ST_IDLE);

endmodule

>>> src/lagged_fibonacci_uniform_rng.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_uniform_rng
// lag-97/33 subtractive uniform generator with weyl carry, 0.24 fixed point
// ----------------------------------------------------------------------------
//
//  channel   signals                      transfer when
//  -------   --------------------------   ------------------------------------
//  command   start, operation, seed       start high while busy low
//  result    valid, value, unseeded       valid high, one cycle, no back-pressure
//
//  a draw reads both table entries into registers in DRAW_RD, then does
//  the subtract, table write-back and carry step together in DRAW_WR
//  a draw before any reseed answers in the next cycle, zero with unseeded set
//  a reseed keeps busy high while four constant divisions (each a compare
//  fold or reciprocal multiply, then the remainder) split the seed, then
//  each of the 97 x 24 table bits runs MUL_AB, QUO_AB, REM_AB, MUL_C,
//  QUO_C, REM_C and BIT for the two mod-179 products and the mod-169 step
//  reset leaves the block unseeded; the lag table is only valid after a reseed
//  results cannot be stalled, each valid cycle is one transfer
//
module lagged_fibonacci_uniform_rng (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [lfur_pkg::SEED_W-1:0]  seed,
    output logic                         valid,
    output logic [23:0]                  value,
    output logic                         unseeded
);

    // command and status between controller and datapath
    lfur_pkg::ctrl_cmd_t    cmd;
    lfur_pkg::ctrl_status_t status;

    // controller decodes the command and walks the fill and draw steps
    lfur_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .busy      (busy),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath holds the lag table, pointers, carry and output register
    lfur_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .seed     (seed),
        .valid    (valid),
        .value    (value),
        .unseeded (unseeded)
    );

endmodule

>>> src/lfur_check.sv
// ----------------------------------------------------------------------------
// lfur_check
// port-level checks on command and result behavior
// ----------------------------------------------------------------------------
module lfur_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         operation,
    input logic [lfur_pkg::SEED_W-1:0]  seed,
    input logic                         valid,
    input logic [23:0]                  value,
    input logic                         unseeded
);

    // an accepted command either starts work or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || valid))
        else $error("accepted command neither busy nor answered");

    // an unseeded answer carries a zero value
    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && unseeded) |-> (value == 24'd0))
        else $error("unseeded result with nonzero value");

    // a result follows either an accept or a busy cycle
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ($past(busy) || $past(start && !busy)))
        else $error("result without a command");

    // a reseed gives no result
    a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !operation) |=> !valid)
        else $error("reseed produced a result");

    // seed only matters on reseed; keep it in the check's view
    a_seed_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !operation) |-> !$isunknown(seed))
        else $error("reseed with unknown seed");

endmodule

bind lagged_fibonacci_uniform_rng lfur_check u_lfur_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .seed      (seed),
    .valid     (valid),
    .value     (value),
    .unseeded  (unseeded)
);

>>> sim/tb_lagged_fibonacci_uniform_rng.sv
// ----------------------------------------------------------------------------
// tb_lagged_fibonacci_uniform_rng
// self-checking bench for the lag-97/33 uniform generator: directed reseeds and
// draws, then random bursts, each sample checked against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_lagged_fibonacci_uniform_rng;

    timeunit 1ns;
    timeprecision 1ps;

    // ranmar arithmetic, kept apart from the design package on purpose
    localparam int unsigned RM_MODULUS   = 899999963;
    localparam int unsigned RM_SPLIT     = 30082;
    localparam int unsigned RM_LAG_LEN   = 97;
    localparam int unsigned RM_LAG_LONG  = 96;
    localparam int unsigned RM_LAG_SHORT = 32;
    localparam bit [23:0]   RM_C_INIT    = 24'd362436;
    localparam bit [23:0]   RM_C_DEC     = 24'd7654321;
    localparam bit [23:0]   RM_C_MOD     = 24'd16777213;

    // stimulus sizing
    localparam int RANDOM_ITEMS   = 1930;
    localparam int RANDOM_RESEEDS = 16;

    typedef struct {
        bit [23:0] value;
        bit        unseeded;
    } sample_t;

    // ------------------------------------------------------------------------
    // scoreboard: owns the predicted generator state and the expected samples
    // ------------------------------------------------------------------------
    class ranmar_scoreboard;
        bit [23:0]   lag_mem [RM_LAG_LEN];
        int unsigned ptr_long;
        int unsigned ptr_short;
        bit [23:0]   weyl;
        bit          is_seeded;
        sample_t     pending_samples [$];
        int          mismatches;
        int          samples_checked;
        int          reseeds_seen;
        int          draws_seen;
        int          unseeded_draws;

        function new();
            foreach (lag_mem[i]) lag_mem[i] = '0;
            ptr_long        = RM_LAG_LONG;
            ptr_short       = RM_LAG_SHORT;
            weyl            = RM_C_INIT;
            is_seeded       = 1'b0;
            mismatches      = 0;
            samples_checked = 0;
            reseeds_seen    = 0;
            draws_seen      = 0;
            unseeded_draws  = 0;
        endfunction

        // reduce the seed, split into i/j/k/l, then fill 97 x 24 bits msb first
        function void refill_lag_mem(bit [30:0] s);
            int unsigned r, hi, lo, si, sj, sk, sl, m;
            bit [23:0]   acc;
            r  = s % RM_MODULUS;
            hi = r / RM_SPLIT;
            lo = r - RM_SPLIT * hi;
            si = ((hi / 177) % 177) + 2;
            sj = (hi % 177) + 2;
            sk = ((lo / 169) % 178) + 1;
            sl = lo % 169;
            for (int entry = 0; entry < RM_LAG_LEN; entry++)
            begin
                acc = '0;
                for (int b_idx = 0; b_idx < 24; b_idx++)
                begin
                    m  = (((si * sj) % 179) * sk) % 179;
                    si = sj;
                    sj = sk;
                    sk = m;
                    sl = (53 * sl + 1) % 169;
                    acc = {acc[22:0], ((sl * m) % 64) >= 32};
                end
                lag_mem[entry] = acc;
            end
            ptr_long  = RM_LAG_LONG;
            ptr_short = RM_LAG_SHORT;
            weyl      = RM_C_INIT;
            is_seeded = 1'b1;
        endfunction

        // one subtractive step with table write-back, then the weyl carry
        function bit [23:0] next_uniform();
            bit [23:0] diff;
            diff = lag_mem[ptr_long] - lag_mem[ptr_short];
            lag_mem[ptr_long] = diff;
            ptr_long  = (ptr_long == 0)  ? RM_LAG_LONG : ptr_long - 1;
            ptr_short = (ptr_short == 0) ? RM_LAG_LONG : ptr_short - 1;
            if (weyl >= RM_C_DEC)
                weyl = weyl - RM_C_DEC;
            else
                weyl = weyl + RM_C_MOD - RM_C_DEC;
            return diff - weyl;
        endfunction

        // called once per accepted command transfer
        function void note_command(logic op, logic [30:0] s);
            sample_t exp_s;
            if (op == lfur_pkg::OP_RESEED)
            begin
                reseeds_seen++;
                refill_lag_mem(s);
            end
            else
            begin
                draws_seen++;
                if (!is_seeded)
                begin
                    unseeded_draws++;
                    exp_s.value    = '0;
                    exp_s.unseeded = 1'b1;
                end
                else
                begin
                    exp_s.value    = next_uniform();
                    exp_s.unseeded = 1'b0;
                end
                pending_samples.push_back(exp_s);
            end
        endfunction

        // called once per result transfer
        function void check_sample(logic [23:0] v, logic u);
            sample_t exp_s;
            if (pending_samples.size() == 0)
            begin
                $display("%0t ns: unexpected sample, expected none, actual value %06h unseeded %0b",
                         $time, v, u);
                mismatches++;
                return;
            end
            exp_s = pending_samples.pop_front();
            samples_checked++;
            if (v !== exp_s.value)
            begin
                $display("%0t ns: value mismatch, expected %06h actual %06h",
                         $time, exp_s.value, v);
                mismatches++;
            end
            if (u !== exp_s.unseeded)
            begin
                $display("%0t ns: unseeded mismatch, expected %0b actual %0b",
                         $time, exp_s.unseeded, u);
                mismatches++;
            end
        endfunction

        // anything still queued at the end never showed up
        function void close_out();
            foreach (pending_samples[i])
            begin
                $display("%0t ns: missing sample, expected %06h unseeded %0b actual none",
                         $time, pending_samples[i].value, pending_samples[i].unseeded);
                mismatches++;
            end
            pending_samples.delete();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut hookup
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = lfur_pkg::OP_DRAW;
    logic [30:0] seed = '0;
    logic        valid;
    logic [23:0] value;
    logic        unseeded;

    ranmar_scoreboard sb;

    lagged_fibonacci_uniform_rng u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .seed      (seed),
        .valid     (valid),
        .value     (value),
        .unseeded  (unseeded)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side: every valid cycle is a transfer, no back-pressure exists,
    // sampled in the active region so we see pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_sample(value, unseeded);
    end

    // ------------------------------------------------------------------------
    // command driver
    // puts one item on the bus and returns at the edge where it transfers;
    // start is left high so a back-to-back item needs no extra edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [30:0] s);
        start     <= 1'b1;
        operation <= op;
        seed      <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(op, s);
    endtask

    // drop start and idle for a number of cycles (gap 0 keeps the burst going)
    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic draw_n(input int n);
        for (int k = 0; k < n; k++)
            send_item(lfur_pkg::OP_DRAW, 31'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int items_left;
        int reseeds_left;
        int burst;
        int gap;
        int drain;

        sb = new();

        // reset once, held before the first command
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: draws before any reseed must answer zero and unseeded,
        // with the ignored seed field at both extremes
        send_item(lfur_pkg::OP_DRAW, '0);
        send_item(lfur_pkg::OP_DRAW, 31'h7FFF_FFFF);
        idle_for(3);
        send_item(lfur_pkg::OP_DRAW, 31'($urandom));

        // smallest seed, then a few draws back to back
        send_item(lfur_pkg::OP_RESEED, '0);
        draw_n(4);
        idle_for(2);

        // largest seed, well beyond the modulus
        send_item(lfur_pkg::OP_RESEED, 31'h7FFF_FFFF);
        draw_n(3);

        // seed equal to the modulus folds back to zero
        send_item(lfur_pkg::OP_RESEED, 31'(RM_MODULUS));
        draw_n(2);
        idle_for(1);

        // one below the modulus, largest reduced value
        send_item(lfur_pkg::OP_RESEED, 31'(RM_MODULUS - 1));
        draw_n(2);
        idle_for(5);

        // random part: bursts of mostly draws with a rare reseed, so that
        // runs longer than 97 draws wrap both lag pointers
        items_left   = RANDOM_ITEMS;
        reseeds_left = RANDOM_RESEEDS;
        while (items_left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && items_left > 0; k++)
            begin
                if (reseeds_left > 0 && $urandom_range(0, 119) == 0)
                begin
                    send_item(lfur_pkg::OP_RESEED, 31'($urandom));
                    reseeds_left--;
                end
                else
                    send_item(lfur_pkg::OP_DRAW, 31'($urandom));
                items_left--;
            end
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 6);
            endcase
            idle_for(gap);
        end
        start <= 1'b0;

        // drain: wait for outstanding samples, then for a trailing reseed,
        // then keep watching for any stray strobe
        drain = 0;
        while (sb.pending_samples.size() > 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        while (busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
        sb.close_out();

        $display("run covered %0d reseeds and %0d draws (%0d before any seed)",
                 sb.reseeds_seen, sb.draws_seen, sb.unseeded_draws);
        $display("%0d samples checked, %0d mismatches", sb.samples_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: a full run needs a few ms, mostly reseed fill time
    initial
    begin
        #20_000_000;
        $display("timeout at %0t ns", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
